[sv/lfucr_pkg.sv]
// shared constants of the lfu cache replacement directory
package lfucr_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned RING_W = 5;

  localparam logic [RING_W-1:0] RING_EMPTY = 5'd31;

endpackage

[sv/lfucr_req_if.sv]
// lookup request channel: one hashed key per beat
interface lfucr_req_if;

  logic                        valid;
  logic                        ready;
  logic [lfucr_pkg::KEY_W-1:0] lookup_key;

  modport source (output valid, output lookup_key, input ready);
  modport sink (input valid, input lookup_key, output ready);

endinterface

[sv/lfucr_rsp_if.sv]
// lookup response channel: hit flag, slot and eviction flag per beat
interface lfucr_rsp_if;

  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lfucr_pkg::SLOT_W-1:0] slot_index;
  logic                         evicted;

  modport source (output valid, output hit, output slot_index, output evicted, input ready);
  modport sink (input valid, input hit, input slot_index, input evicted, output ready);

endinterface

[sv/lfucr_pick.sv]
// victim tracker: running minimum of use counts over non-recent slots
module lfucr_pick #(
  parameter int unsigned NUM_SLOTS    = 16,
  parameter int unsigned RECENT_DEPTH = 5,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                clear_i,
  input  logic                                                step_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]                        idx_i,
  input  logic [COUNT_BITS-1:0]                               cnt_i,
  input  logic [RECENT_DEPTH-1:0][lfucr_pkg::RING_W-1:0]      ring_i,
  output logic [$clog2(NUM_SLOTS)-1:0]                        victim_o
);

  localparam int unsigned IDXW = $clog2(NUM_SLOTS);
  localparam int unsigned CMPW = (IDXW > lfucr_pkg::RING_W) ? IDXW : lfucr_pkg::RING_W;

  logic [COUNT_BITS:0] best_q, best_d;
  logic [IDXW-1:0]     victim_q, victim_d;
  logic                recent;
  logic                cand;

  always_comb begin
    recent = 1'b0;
    for (int k = 0; k < RECENT_DEPTH; k++) begin
      if (ring_i[k] != lfucr_pkg::RING_EMPTY && CMPW'(ring_i[k]) == CMPW'(idx_i)) begin
        recent = 1'b1;
      end
    end
  end

  assign cand     = step_i && !recent && ({1'b0, cnt_i} < best_q);
  assign victim_o = cand ? idx_i : victim_q;

  always_comb begin
    best_d   = best_q;
    victim_d = victim_q;
    if (clear_i) begin
      best_d   = {1'b1, {COUNT_BITS{1'b0}}};
      victim_d = '0;
    end else if (cand) begin
      best_d   = {1'b0, cnt_i};
      victim_d = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= {1'b1, {COUNT_BITS{1'b0}}};
      victim_q <= '0;
    end else begin
      best_q   <= best_d;
      victim_q <= victim_d;
    end
  end

endmodule

[sv/lfu_cache_replace_excluding_recent_top.sv]
// Fully associative cache directory with lfu replacement that skips the most recently used
// slots. Each request beat carries one 64-bit key; the block walks the tag and count memories
// one slot per cycle, comparing the key and tracking the least used non-recent slot in the same
// pass. A hit ends the scan at the matching slot, a miss ends it after the last slot; an update
// step then writes the slot memories once the output register is free, and only then does the
// block return to idle for a new request. The single read port of the slot memories keeps the
// walk sequential. A new request is taken while a finished response still waits on the output.
module lfu_cache_replace_excluding_recent_top #(
  parameter int unsigned NUM_SLOTS    = 16,
  parameter int unsigned RECENT_DEPTH = 5,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lfucr_req_if.sink      req_i,
  lfucr_rsp_if.source    rsp_o
);

  localparam int unsigned IDXW = $clog2(NUM_SLOTS);
  localparam int unsigned PTRW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);
  localparam logic [PTRW-1:0] LAST_PTR = PTRW'(RECENT_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e                                            state_q;
  logic [lfucr_pkg::KEY_W-1:0]                       key_q;
  logic [IDXW-1:0]                                   rd_idx_q;
  logic                                              issue_done_q;
  logic                                              pipe_vld_q;
  logic [IDXW-1:0]                                   pipe_idx_q;
  logic [IDXW-1:0]                                   sel_idx_q;
  logic                                              sel_hit_q;
  logic [COUNT_BITS-1:0]                             sel_cnt_q;
  logic [NUM_SLOTS-1:0]                              slot_valid_q;
  logic [RECENT_DEPTH-1:0][lfucr_pkg::RING_W-1:0]    ring_q;
  logic [PTRW-1:0]                                   ptr_q;
  logic                                              rsp_valid_q;
  logic                                              rsp_hit_q;
  logic [lfucr_pkg::SLOT_W-1:0]                      rsp_slot_q;
  logic                                              rsp_evicted_q;

  // slot memories
  logic [lfucr_pkg::KEY_W-1:0] tag_mem_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0]       cnt_mem_q [NUM_SLOTS];
  logic [lfucr_pkg::KEY_W-1:0] tag_rd_q;
  logic [COUNT_BITS-1:0]       cnt_rd_q;

  logic                  in_fire;
  logic                  cmp_vld;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic                  pipe_hit;
  logic                  commit;
  logic [COUNT_BITS-1:0] cnt_wr;
  logic [IDXW-1:0]       victim_next;

  assign req_i.ready      = (state_q == ST_IDLE);
  assign in_fire          = req_i.valid && req_i.ready;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.slot_index = rsp_slot_q;
  assign rsp_o.evicted    = rsp_evicted_q;

  // an invalid slot counts as zero whatever its memory holds
  assign cmp_vld  = (state_q == ST_SCAN) && pipe_vld_q;
  assign cnt_eff  = slot_valid_q[pipe_idx_q] ? cnt_rd_q : '0;
  assign pipe_hit = cmp_vld && slot_valid_q[pipe_idx_q] && (tag_rd_q == key_q);
  assign commit   = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp_o.ready);
  assign cnt_wr   = !sel_hit_q ? COUNT_BITS'(1)
                  : ((sel_cnt_q == {COUNT_BITS{1'b1}}) ? sel_cnt_q : sel_cnt_q + 1'b1);

  lfucr_pick #(
    .NUM_SLOTS    (NUM_SLOTS),
    .RECENT_DEPTH (RECENT_DEPTH),
    .COUNT_BITS   (COUNT_BITS)
  ) u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_fire),
    .step_i   (cmp_vld && !pipe_hit),
    .idx_i    (pipe_idx_q),
    .cnt_i    (cnt_eff),
    .ring_i   (ring_q),
    .victim_o (victim_next)
  );

  always_ff @(posedge clk_i) begin
    tag_rd_q <= tag_mem_q[rd_idx_q];
    cnt_rd_q <= cnt_mem_q[rd_idx_q];
    if (commit) begin
      cnt_mem_q[sel_idx_q] <= cnt_wr;
      if (!sel_hit_q) begin
        tag_mem_q[sel_idx_q] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      key_q         <= '0;
      rd_idx_q      <= '0;
      issue_done_q  <= 1'b0;
      pipe_vld_q    <= 1'b0;
      pipe_idx_q    <= '0;
      sel_idx_q     <= '0;
      sel_hit_q     <= 1'b0;
      sel_cnt_q     <= '0;
      slot_valid_q  <= '0;
      ring_q        <= {RECENT_DEPTH{lfucr_pkg::RING_EMPTY}};
      ptr_q         <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_hit_q     <= 1'b0;
      rsp_slot_q    <= '0;
      rsp_evicted_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && !commit) begin
        rsp_valid_q <= 1'b0;
      end
      pipe_vld_q <= (state_q == ST_SCAN) && !issue_done_q;
      pipe_idx_q <= rd_idx_q;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            key_q        <= req_i.lookup_key;
            rd_idx_q     <= '0;
            issue_done_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!issue_done_q) begin
            if (rd_idx_q == LAST_IDX) begin
              issue_done_q <= 1'b1;
            end else begin
              rd_idx_q <= rd_idx_q + 1'b1;
            end
          end
          if (pipe_hit) begin
            sel_idx_q <= pipe_idx_q;
            sel_hit_q <= 1'b1;
            sel_cnt_q <= cnt_eff;
            state_q   <= ST_UPDATE;
          end else if (cmp_vld && pipe_idx_q == LAST_IDX) begin
            sel_idx_q <= victim_next;
            sel_hit_q <= 1'b0;
            state_q   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (commit) begin
            rsp_valid_q   <= 1'b1;
            rsp_hit_q     <= sel_hit_q;
            rsp_slot_q    <= lfucr_pkg::SLOT_W'(sel_idx_q);
            rsp_evicted_q <= !sel_hit_q && slot_valid_q[sel_idx_q];
            slot_valid_q[sel_idx_q] <= 1'b1;
            for (int k = 0; k < RECENT_DEPTH; k++) begin
              if (PTRW'(k) == ptr_q) begin
                ring_q[k] <= lfucr_pkg::RING_W'(sel_idx_q);
              end
            end
            ptr_q   <= (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a response only appears out of the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == ST_UPDATE)
    else $error("response raised outside update");

  // the slot just reported is marked valid from then on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> slot_valid_q[sel_idx_q])
    else $error("reported slot not marked valid");

  // ring pointer never leaves the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LAST_PTR)
    else $error("ring pointer out of range");
`endif

endmodule

[sim/lfu_cache_replace_excluding_recent_top_tb.sv]
// self-checking testbench for the lfu cache directory: directed fills and random lookups
`timescale 1ns / 1ps

module lfu_cache_replace_excluding_recent_top_tb;

  localparam int unsigned NUM_SLOTS    = 16;
  localparam int unsigned RECENT_DEPTH = 5;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned DRAIN_CYCLES = NUM_SLOTS + 12;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned KEY_W        = lfucr_pkg::KEY_W;
  localparam int unsigned SLOT_W       = lfucr_pkg::SLOT_W;
  localparam int unsigned RING_W       = lfucr_pkg::RING_W;
  localparam logic [RING_W-1:0] RING_EMPTY = lfucr_pkg::RING_EMPTY;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot_index;
    logic              evicted;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;

  lfucr_req_if req_if ();
  lfucr_rsp_if rsp_if ();

  lfu_cache_replace_excluding_recent_top #(
    .NUM_SLOTS   (NUM_SLOTS),
    .RECENT_DEPTH(RECENT_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // directory shadow
  logic [KEY_W-1:0]      dir_tag      [NUM_SLOTS];
  logic                  dir_valid    [NUM_SLOTS];
  logic [COUNT_BITS-1:0] dir_count    [NUM_SLOTS];
  logic [RING_W-1:0]     recent_slots [RECENT_DEPTH];
  int unsigned           recent_wr_ptr;

  lookup_result_t pending_lookups[$];
  int unsigned    error_count;
  int unsigned    cycle_count;
  bit             idling_on;
  int unsigned    stall_left;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void push_recent(input int unsigned slot);
    recent_slots[recent_wr_ptr] = RING_W'(slot);
    recent_wr_ptr = (recent_wr_ptr == RECENT_DEPTH - 1) ? 0 : recent_wr_ptr + 1;
  endfunction

  function automatic lookup_result_t lookup_directory(input logic [KEY_W-1:0] key);
    lookup_result_t res;
    int unsigned    best;
    int unsigned    victim;
    bit             is_recent;
    int unsigned    s;
    int unsigned    k;
    res = '0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (dir_valid[s] && dir_tag[s] == key) begin
        if (dir_count[s] != COUNT_MAX) begin
          dir_count[s] = dir_count[s] + 1'b1;
        end
        push_recent(s);
        res.hit        = 1'b1;
        res.slot_index = SLOT_W'(s);
        return res;
      end
    end
    // least used slot outside the recent ring, lowest index on ties
    best   = COUNT_MAX + 1;
    victim = 0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      is_recent = 1'b0;
      for (k = 0; k < RECENT_DEPTH; k++) begin
        if (recent_slots[k] != RING_EMPTY && recent_slots[k] == RING_W'(s)) begin
          is_recent = 1'b1;
        end
      end
      if (dir_count[s] < best && !is_recent) begin
        best   = dir_count[s];
        victim = s;
      end
    end
    res.slot_index    = SLOT_W'(victim);
    res.evicted       = dir_valid[victim];
    dir_tag[victim]   = key;
    dir_valid[victim] = 1'b1;
    dir_count[victim] = COUNT_BITS'(1);
    push_recent(victim);
    return res;
  endfunction

  // predict on every request beat, check every response beat
  always @(posedge clk_i) begin : check_beats
    lookup_result_t exp;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        pending_lookups.push_back(lookup_directory(req_if.lookup_key));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_lookups.size() == 0) begin
          $error("response beat with no lookup outstanding");
          error_count++;
        end else begin
          exp = pending_lookups.pop_front();
          if (rsp_if.hit !== exp.hit) begin
            $error("hit: expected %0d, got %0d", exp.hit, rsp_if.hit);
            error_count++;
          end
          if (rsp_if.slot_index !== exp.slot_index) begin
            $error("slot_index: expected %0d, got %0d", exp.slot_index, rsp_if.slot_index);
            error_count++;
          end
          if (rsp_if.evicted !== exp.evicted) begin
            $error("evicted: expected %0d, got %0d", exp.evicted, rsp_if.evicted);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // response side back-pressure
  initial begin
    rsp_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // one request beat; valid stays up unless a gap follows
  task automatic send_key(input logic [KEY_W-1:0] key);
    req_if.valid      <= 1'b1;
    req_if.lookup_key <= key;
    do @(posedge clk_i); while (!req_if.ready);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // step the clock before the first check so the beat accepted just now is already counted
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_lookups.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // fill all slots from reset, extreme keys first, then hit the last slot and slot 3 again
  task automatic test_fill_and_hit();
    int unsigned k;
    send_key('0);
    send_key('1);
    send_key('0);
    send_key('1);
    send_key({(KEY_W/2){2'b01}});
    send_key({(KEY_W/2){2'b10}});
    for (k = 0; k < NUM_SLOTS - 4; k++) begin
      send_key(KEY_W'(1) << (k * 5));
    end
    send_key(KEY_W'(1) << 55);
    send_key({(KEY_W/2){2'b10}});
  endtask

  // full directory: misses must evict the least used slot that is not recent
  task automatic test_eviction_skips_recent();
    send_key(64'h8000_0000_0000_0001);
    send_key(64'h7fff_ffff_ffff_fffe);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'h0123_4567_89ab_cdef);
    send_key('0);
    send_key(64'hfedc_ba98_7654_3210);
    hold_until_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned i;
    int unsigned pick;
    int unsigned s;
    for (i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = random_key();
    end
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idling_on = ((i / 100) % 4) != 3;
      if (i == RANDOM_ITEMS / 2) begin
        hold_until_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_key(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (pick < 80) begin
        // a resident tag, so the hit lands on an arbitrary slot
        s = $urandom_range(0, NUM_SLOTS - 1);
        send_key(dir_valid[s] ? dir_tag[s] : random_key());
      end else begin
        send_key(random_key());
      end
    end
    hold_until_drained();
  endtask

  initial begin : run_tests
    int unsigned s;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.lookup_key <= '0;
    idling_on   = 1'b1;
    error_count = 0;
    cycle_count = 0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      dir_tag[s]   = '0;
      dir_valid[s] = 1'b0;
      dir_count[s] = '0;
    end
    for (s = 0; s < RECENT_DEPTH; s++) begin
      recent_slots[s] = RING_EMPTY;
    end
    recent_wr_ptr = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_hit();
    test_eviction_skips_recent();
    test_random_traffic();

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
